FILE: sv/wsf_pkg.sv
// ---------------------------------------------------------------------------
// WAV stream package
// Shared types, constants and helpers of the WAV byte stream to stereo
// frame converter.
// ---------------------------------------------------------------------------
package wsf_pkg;

   // Depth of the result queue between the parser and the output stage.
   localparam int QueueDepthDefault = 4;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_TRUNCATED   = 2'd1;
   localparam logic [1:0] ERR_STRUCTURE   = 2'd2;
   localparam logic [1:0] ERR_UNSUPPORTED = 2'd3;

   // Chunk tags as little-endian words.
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] PCM_CODE   = 16'd1;
   localparam logic [15:0] PCM_BITS   = 16'd16;
   localparam logic [15:0] MAX_CH     = 16'd2;
   localparam logic [4:0]  FMT_BYTES  = 5'd16;

   // Width of the packed response data, rounded up to whole bytes.
   localparam int RspDataWidth = 72;

   // One result item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] left_sample;
      logic [15:0] right_sample;
      logic [1:0]  channel_count;
      logic [31:0] rate_hz;
      logic [1:0]  error_code;
   } result_type;

   // Builds a result item.
   function automatic result_type make_result(input logic [1:0] kind,
                                              input logic [15:0] left,
                                              input logic [15:0] right,
                                              input logic [1:0] chans,
                                              input logic [31:0] rate,
                                              input logic [1:0] err);
      result_type r;
      r.kind          = kind;
      r.left_sample   = left;
      r.right_sample  = right;
      r.channel_count = chans;
      r.rate_hz       = rate;
      r.error_code    = err;
      return r;
   endfunction

endpackage

FILE: sv/wsf_parser.sv
// ---------------------------------------------------------------------------
// WAV stream parser
// Takes file bytes, walks the RIFF chunks and pushes header, frame, error
// and end results into the result queue.
// ---------------------------------------------------------------------------
module wsf_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic [15:0]         csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_byte,
   input  logic                req_first,
   input  logic                req_eof,
   input  logic                queue_room,
   output logic                push_valid,
   output wsf_pkg::result_type push_data
);

   typedef enum logic [7:0] {
      PH_PRE  = 8'b0000_0001,
      PH_HDR  = 8'b0000_0010,
      PH_FMT  = 8'b0000_0100,
      PH_SKIP = 8'b0000_1000,
      PH_DATA = 8'b0001_0000,
      PH_DONE = 8'b0010_0000,
      PH_LIM  = 8'b0100_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [32:0] skip_ff, skip_in;
   logic [15:0] fcode_ff, fcode_in;
   logic [15:0] fch_ff, fch_in;
   logic [31:0] frate_ff, frate_in;
   logic [15:0] fbits_ff, fbits_in;
   logic        seen_ff, seen_in;
   logic [31:0] dleft_ff, dleft_in;
   logic [31:0] fbytes_ff, fbytes_in;
   logic [1:0]  fidx_ff, fidx_in;
   logic        pend_ff, pend_in;
   logic        eofp_ff, eofp_in;
   logic [15:0] dur_ff, dur_in;
   logic [47:0] prod_ff, prod_in;
   logic        accept;

   assign req_tready = queue_room && !pend_ff && (phase_ff != PH_LIM);
   assign accept     = req_tvalid && req_tready;
   assign dur_in     = csr_wen ? csr_wdata : dur_ff;
   // The limit product is registered every cycle and used in the limit step.
   assign prod_in    = {32'd0, dur_ff} * {16'd0, frate_ff};

   // Next-state logic of the chunk walker.
   always_comb begin
      logic [3:0]  i;
      logic [4:0]  need;
      logic [2:0]  k;
      logic [2:0]  bpf;
      logic [31:0] frames;
      logic [31:0] dbl;
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      tag_in     = tag_ff;
      len_in     = len_ff;
      skip_in    = skip_ff;
      fcode_in   = fcode_ff;
      fch_in     = fch_ff;
      frate_in   = frate_ff;
      fbits_in   = fbits_ff;
      seen_in    = seen_ff;
      dleft_in   = dleft_ff;
      fbytes_in  = fbytes_ff;
      fidx_in    = fidx_ff;
      pend_in    = 1'b0;
      eofp_in    = eofp_ff;
      push_valid = 1'b0;
      push_data  = wsf_pkg::make_result(wsf_pkg::KIND_END, '0, '0, '0, '0,
                                        wsf_pkg::ERR_NONE);
      bpf        = (fch_ff == wsf_pkg::MAX_CH) ? 3'd4 : 3'd2;
      frames     = '0;
      dbl        = '0;
      need       = '0;
      k          = '0;
      i          = '0;
      if (pend_ff) begin
         // Second result of the previous request: end of playback.
         push_valid = 1'b1;
      end else if (phase_ff == PH_LIM) begin
         // Frame count from the data length, clipped by the duration limit.
         frames = (bpf == 3'd4) ? (len_ff >> 2) : (len_ff >> 1);
         if (dur_ff != '0 && prod_ff < {16'd0, frames}) begin
            frames = prod_ff[31:0];
         end
         dbl = (bpf == 3'd4) ? (frames << 2) : (frames << 1);
         dleft_in  = dbl;
         fbytes_in = '0;
         fidx_in   = '0;
         if (dbl == '0 || eofp_ff) begin
            phase_in   = PH_DONE;
            push_valid = 1'b1;
         end else begin
            phase_in = PH_DATA;
         end
      end else if (accept) begin
         if (req_first) begin
            phase_in  = PH_PRE;
            cnt_in    = '0;
            tag_in    = '0;
            len_in    = '0;
            skip_in   = '0;
            fcode_in  = '0;
            fch_in    = '0;
            frate_in  = '0;
            fbits_in  = '0;
            seen_in   = 1'b0;
            dleft_in  = '0;
            fbytes_in = '0;
            fidx_in   = '0;
         end
         i    = cnt_in;
         bpf  = (fch_in == wsf_pkg::MAX_CH) ? 3'd4 : 3'd2;
         need = (len_in < 32'd16) ? len_in[4:0] : wsf_pkg::FMT_BYTES;
         unique case (phase_in)
            PH_PRE: begin
               if (i < 4'd4) begin
                  tag_in[8*i[1:0] +: 8] = tag_in[8*i[1:0] +: 8] | req_byte;
               end else if (i >= 4'd8) begin
                  len_in[8*i[1:0] +: 8] = len_in[8*i[1:0] +: 8] | req_byte;
               end
               cnt_in = i + 4'd1;
               if (i >= 4'd11) begin
                  if (tag_in != wsf_pkg::TAG_RIFF || len_in != wsf_pkg::TAG_WAVE) begin
                     phase_in   = PH_DONE;
                     push_valid = 1'b1;
                     push_data  = wsf_pkg::make_result(wsf_pkg::KIND_ERROR, '0, '0,
                                     '0, '0, wsf_pkg::ERR_STRUCTURE);
                  end else begin
                     tag_in   = '0;
                     len_in   = '0;
                     cnt_in   = '0;
                     phase_in = PH_HDR;
                  end
               end
            end
            PH_HDR: begin
               if (i == 4'd0) begin
                  tag_in = '0;
                  len_in = '0;
               end
               if (i < 4'd4) begin
                  tag_in[8*i[1:0] +: 8] = tag_in[8*i[1:0] +: 8] | req_byte;
               end else begin
                  len_in[8*i[1:0] +: 8] = len_in[8*i[1:0] +: 8] | req_byte;
               end
               cnt_in = i + 4'd1;
               need   = (len_in < 32'd16) ? len_in[4:0] : wsf_pkg::FMT_BYTES;
               if (i >= 4'd7) begin
                  if (tag_in == wsf_pkg::TAG_FMT) begin
                     fcode_in = '0;
                     fch_in   = '0;
                     frate_in = '0;
                     fbits_in = '0;
                     if (len_in == '0) begin
                        phase_in   = PH_DONE;
                        push_valid = 1'b1;
                        push_data  = wsf_pkg::make_result(wsf_pkg::KIND_ERROR, '0,
                                        '0, '0, '0, wsf_pkg::ERR_UNSUPPORTED);
                     end else begin
                        cnt_in   = '0;
                        phase_in = PH_FMT;
                     end
                  end else if (tag_in == wsf_pkg::TAG_DATA) begin
                     push_valid = 1'b1;
                     if (!seen_in) begin
                        phase_in  = PH_DONE;
                        push_data = wsf_pkg::make_result(wsf_pkg::KIND_ERROR, '0,
                                       '0, '0, '0, wsf_pkg::ERR_STRUCTURE);
                     end else if (frate_in == '0 || fbits_in != wsf_pkg::PCM_BITS ||
                                  (fch_in != 16'd1 && fch_in != wsf_pkg::MAX_CH)) begin
                        phase_in  = PH_DONE;
                        push_data = wsf_pkg::make_result(wsf_pkg::KIND_ERROR, '0,
                                       '0, '0, '0, wsf_pkg::ERR_UNSUPPORTED);
                     end else begin
                        phase_in  = PH_LIM;
                        eofp_in   = req_eof;
                        push_data = wsf_pkg::make_result(wsf_pkg::KIND_HEADER, '0,
                                       '0, fch_in[1:0], frate_in, wsf_pkg::ERR_NONE);
                     end
                  end else begin
                     skip_in  = {1'b0, len_in} + {32'd0, len_in[0]};
                     cnt_in   = '0;
                     phase_in = (skip_in == '0) ? PH_HDR : PH_SKIP;
                  end
               end
            end
            PH_FMT: begin
               if (i < 4'd2) begin
                  fcode_in[8*i[0] +: 8] = fcode_in[8*i[0] +: 8] | req_byte;
               end else if (i < 4'd4) begin
                  fch_in[8*i[0] +: 8] = fch_in[8*i[0] +: 8] | req_byte;
               end else if (i < 4'd8) begin
                  frate_in[8*i[1:0] +: 8] = frate_in[8*i[1:0] +: 8] | req_byte;
               end else if (i >= 4'd14) begin
                  fbits_in[8*i[0] +: 8] = fbits_in[8*i[0] +: 8] | req_byte;
               end
               cnt_in = i + 4'd1;
               if ({1'b0, i} + 5'd1 >= need) begin
                  if (fcode_in != wsf_pkg::PCM_CODE) begin
                     phase_in   = PH_DONE;
                     push_valid = 1'b1;
                     push_data  = wsf_pkg::make_result(wsf_pkg::KIND_ERROR, '0, '0,
                                     '0, '0, wsf_pkg::ERR_UNSUPPORTED);
                  end else begin
                     seen_in  = 1'b1;
                     skip_in  = {1'b0, len_in - {27'd0, need}} + {32'd0, len_in[0]};
                     cnt_in   = '0;
                     phase_in = (skip_in == '0) ? PH_HDR : PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               if (skip_in != '0) begin
                  skip_in = skip_in - 33'd1;
               end
               if (skip_in == '0) begin
                  cnt_in   = '0;
                  phase_in = PH_HDR;
               end
            end
            PH_DATA: begin
               fbytes_in[8*fidx_in +: 8] = fbytes_in[8*fidx_in +: 8] | req_byte;
               k       = {1'b0, fidx_in} + 3'd1;
               fidx_in = k[1:0];
               if (k >= bpf) begin
                  push_valid = 1'b1;
                  push_data  = wsf_pkg::make_result(wsf_pkg::KIND_FRAME,
                                  fbytes_in[15:0],
                                  (bpf == 3'd4) ? fbytes_in[31:16] : fbytes_in[15:0],
                                  '0, '0, wsf_pkg::ERR_NONE);
                  fbytes_in = '0;
                  fidx_in   = '0;
                  dleft_in  = (dleft_in > {29'd0, bpf}) ? dleft_in - {29'd0, bpf} : '0;
                  if (dleft_in == '0) begin
                     phase_in = PH_DONE;
                     pend_in  = 1'b1;
                  end
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
         // End of file before the parse has finished.
         if (req_eof && phase_in != PH_DONE && phase_in != PH_LIM) begin
            if (phase_in == PH_DATA) begin
               phase_in = PH_DONE;
               if (push_valid) begin
                  pend_in = 1'b1;
               end else begin
                  push_valid = 1'b1;
               end
            end else begin
               push_valid = 1'b1;
               if (phase_in == PH_PRE || phase_in == PH_FMT ||
                   (phase_in == PH_HDR && cnt_in != '0)) begin
                  push_data = wsf_pkg::make_result(wsf_pkg::KIND_ERROR, '0, '0,
                                 '0, '0, wsf_pkg::ERR_TRUNCATED);
               end else begin
                  push_data = wsf_pkg::make_result(wsf_pkg::KIND_ERROR, '0, '0,
                                 '0, '0, wsf_pkg::ERR_STRUCTURE);
               end
               phase_in = PH_DONE;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PRE;
         cnt_ff   <= '0;
         seen_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         eofp_ff  <= 1'b0;
         dur_ff   <= '0;
         tag_ff   <= '0;
         len_ff   <= '0;
         skip_ff  <= '0;
         fcode_ff <= '0;
         fch_ff   <= '0;
         frate_ff <= '0;
         fbits_ff <= '0;
         dleft_ff <= '0;
         fbytes_ff <= '0;
         fidx_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         seen_ff  <= seen_in;
         pend_ff  <= pend_in;
         eofp_ff  <= eofp_in;
         dur_ff   <= dur_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         skip_ff  <= skip_in;
         fcode_ff <= fcode_in;
         fch_ff   <= fch_in;
         frate_ff <= frate_in;
         fbits_ff <= fbits_in;
         dleft_ff <= dleft_in;
         fbytes_ff <= fbytes_in;
         fidx_ff  <= fidx_in;
      end
   end

   // Limit product register.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: sv/wsf_queue.sv
// ---------------------------------------------------------------------------
// WAV stream result queue
// Small first-in first-out store of results between parser and output.
// ---------------------------------------------------------------------------
module wsf_queue #(
   parameter int Depth = wsf_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  wsf_pkg::result_type push_data,
   input  logic                pop,
   output logic                not_empty,
   output wsf_pkg::result_type head,
   output logic                room
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   wsf_pkg::result_type     store_ff [Depth];
   logic [PtrWidth-1:0]     wr_ff, wr_in;
   logic [PtrWidth-1:0]     rd_ff, rd_in;
   logic [CntWidth-1:0]     count_ff, count_in;

   // Two free entries are needed before the parser may take a request.
   assign room      = (count_ff <= CntWidth'(Depth - 2));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push_valid) begin
         wr_in = (wr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/wsf_output.sv
// ---------------------------------------------------------------------------
// WAV stream output stage
// Output register that presents one result at a time on the response side.
// ---------------------------------------------------------------------------
module wsf_output (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  wsf_pkg::result_type head,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [wsf_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic [1:0]          rsp_tuser
);

   logic                valid_ff, valid_in;
   wsf_pkg::result_type res_ff, res_in;

   // Load a new result whenever the register is empty or being taken.
   assign pop      = not_empty && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);
   assign res_in   = pop ? head : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tdata  = {4'd0, res_ff.error_code, res_ff.rate_hz, res_ff.channel_count,
                        res_ff.right_sample, res_ff.left_sample};

endmodule

FILE: sv/wav_stream_to_stereo_frames.sv
// ---------------------------------------------------------------------------
// WAV stream to stereo frames
// Parses a WAV file given one byte per request and delivers the header,
// stereo frames, errors and the end of playback as response items.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while the result queue has room. A byte
// that causes two results holds the request side while the second one is
// pushed, and the data chunk header holds it for the limit step that uses
// the registered duration product.
// Reset: synchronous; clears the parser to the preamble, empties the queue
// and sets the duration limit to zero.
module wav_stream_to_stereo_frames #(
   parameter int QueueDepth = wsf_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata,    // duration_limit
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // byte_value
   input  logic        req_tuser,    // first_byte
   input  logic        req_tlast,    // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // left_sample[15:0], right_sample[31:16], channel_count[33:32],
   // rate_hz[65:34], error_code[67:66], zero fill
   output logic [wsf_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic [1:0]  rsp_tuser     // kind
);

   logic                push_valid;
   wsf_pkg::result_type push_data;
   logic                room;
   logic                pop;
   logic                not_empty;
   wsf_pkg::result_type head;

   wsf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_first  (req_tuser),
      .req_eof    (req_tlast),
      .queue_room (room),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   wsf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head),
      .room       (room)
   );

   wsf_output u_output (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: sv/wsf_checker.sv
// ---------------------------------------------------------------------------
// WAV stream port checker
// Checks result fields and the response handshake seen at the ports.
// ---------------------------------------------------------------------------
module wsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [wsf_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // An error result always carries a nonzero code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == wsf_pkg::KIND_ERROR |-> rsp_tdata[67:66] != '0)
      else $error("error result without code");

   // A header result names one or two channels and a nonzero rate.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == wsf_pkg::KIND_HEADER |->
         (rsp_tdata[33:32] == 2'd1 || rsp_tdata[33:32] == 2'd2) && rsp_tdata[65:34] != '0)
      else $error("header result with bad format fields");

endmodule

bind wav_stream_to_stereo_frames wsf_checker u_wsf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/wav_frame_checker.sv
// ---------------------------------------------------------------------------
// WAV frame checker
// Watches the request, response and register ports of the WAV stream
// converter. It keeps its own parser state, works out the results of every
// accepted request byte and compares each response item with them in order.
// ---------------------------------------------------------------------------
module wav_frame_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [15:0]                      csr_wdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [wsf_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic [1:0]                       rsp_tuser,
   output int                               fail_count,
   output int                               pending_count,
   output int                               frames_checked,
   output int                               headers_checked,
   output int                               errors_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PH_PREAMBLE, PH_CHUNK_HDR, PH_FORMAT, PH_SKIP, PH_DATA, PH_DONE
   } parse_phase_type;

   // Shadow copy of the register and of the parser state.
   logic [15:0]     duration_secs;
   parse_phase_type phase;
   logic [3:0]      byte_cnt;
   logic [31:0]     chunk_tag;
   logic [31:0]     chunk_len;
   logic [32:0]     skip_left;
   logic [15:0]     fmt_code;
   logic [15:0]     fmt_chans;
   logic [31:0]     fmt_rate;
   logic [15:0]     fmt_bits;
   logic            fmt_seen;
   logic [31:0]     data_left;
   logic [31:0]     frame_word;
   logic [1:0]      frame_idx;

   wsf_pkg::result_type expected_results[$];

   assign pending_count = expected_results.size();

   task automatic report(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic push_result(input logic [1:0] kind, input logic [15:0] left,
                              input logic [15:0] right, input logic [1:0] chans,
                              input logic [31:0] rate, input logic [1:0] err);
      wsf_pkg::result_type r;
      r.kind          = kind;
      r.left_sample   = left;
      r.right_sample  = right;
      r.channel_count = chans;
      r.rate_hz       = rate;
      r.error_code    = err;
      expected_results.push_back(r);
   endtask

   task automatic raise_error(input logic [1:0] err);
      phase = PH_DONE;
      push_result(wsf_pkg::KIND_ERROR, '0, '0, '0, '0, err);
   endtask

   task automatic clear_parse();
      phase      = PH_PREAMBLE;
      byte_cnt   = '0;
      chunk_tag  = '0;
      chunk_len  = '0;
      skip_left  = '0;
      fmt_code   = '0;
      fmt_chans  = '0;
      fmt_rate   = '0;
      fmt_bits   = '0;
      fmt_seen   = 1'b0;
      data_left  = '0;
      frame_word = '0;
      frame_idx  = '0;
   endtask

   task automatic start_skip(input logic [32:0] count);
      skip_left = count;
      byte_cnt  = '0;
      phase     = (count == 0) ? PH_CHUNK_HDR : PH_SKIP;
   endtask

   // Works out the results of one request byte and advances the state.
   task automatic predict_byte(input logic [7:0] b, input logic first,
                               input logic eof);
      logic [3:0]  i;
      logic [31:0] need;
      logic [63:0] frame_size;
      logic [63:0] frames;
      logic [63:0] cap;
      logic [2:0]  bpf;
      logic [2:0]  k;
      logic [15:0] left;
      if (first)
         clear_parse();
      i = byte_cnt;
      case (phase)
         PH_PREAMBLE: begin
            if (i < 4)
               chunk_tag[8*i +: 8] = chunk_tag[8*i +: 8] | b;
            else if (i >= 8 && i < 12)
               chunk_len[8*(i-8) +: 8] = chunk_len[8*(i-8) +: 8] | b;
            byte_cnt = i + 4'd1;
            if (i >= 11) begin
               if (chunk_tag != wsf_pkg::TAG_RIFF || chunk_len != wsf_pkg::TAG_WAVE) begin
                  raise_error(wsf_pkg::ERR_STRUCTURE);
               end else begin
                  chunk_tag = '0;
                  chunk_len = '0;
                  byte_cnt  = '0;
                  phase     = PH_CHUNK_HDR;
               end
            end
         end
         PH_CHUNK_HDR: begin
            if (i == 0) begin
               chunk_tag = '0;
               chunk_len = '0;
            end
            if (i < 4)
               chunk_tag[8*i +: 8] = chunk_tag[8*i +: 8] | b;
            else
               chunk_len[8*((i-4)&3) +: 8] = chunk_len[8*((i-4)&3) +: 8] | b;
            byte_cnt = i + 4'd1;
            if (i >= 7) begin
               if (chunk_tag == wsf_pkg::TAG_FMT) begin
                  // A new format chunk replaces every earlier field.
                  fmt_code  = '0;
                  fmt_chans = '0;
                  fmt_rate  = '0;
                  fmt_bits  = '0;
                  if (chunk_len == 0) begin
                     raise_error(wsf_pkg::ERR_UNSUPPORTED);
                  end else begin
                     byte_cnt = '0;
                     phase    = PH_FORMAT;
                  end
               end else if (chunk_tag == wsf_pkg::TAG_DATA) begin
                  if (!fmt_seen) begin
                     raise_error(wsf_pkg::ERR_STRUCTURE);
                  end else if (fmt_rate == 0 || fmt_bits != wsf_pkg::PCM_BITS ||
                               (fmt_chans != 1 && fmt_chans != wsf_pkg::MAX_CH)) begin
                     raise_error(wsf_pkg::ERR_UNSUPPORTED);
                  end else begin
                     push_result(wsf_pkg::KIND_HEADER, '0, '0, fmt_chans[1:0], fmt_rate,
                                 wsf_pkg::ERR_NONE);
                     frame_size = {48'd0, fmt_chans} * 64'd2;
                     frames     = {32'd0, chunk_len} / frame_size;
                     // The duration cap is an exact 48-bit product.
                     if (duration_secs != 0) begin
                        cap = {48'd0, duration_secs} * {32'd0, fmt_rate};
                        if (cap < frames)
                           frames = cap;
                     end
                     data_left  = 32'(frames * frame_size);
                     frame_word = '0;
                     frame_idx  = '0;
                     phase      = PH_DATA;
                     if (data_left == 0) begin
                        phase = PH_DONE;
                        push_result(wsf_pkg::KIND_END, '0, '0, '0, '0, wsf_pkg::ERR_NONE);
                     end
                  end
               end else begin
                  start_skip({1'b0, chunk_len} + chunk_len[0]);
               end
            end
         end
         PH_FORMAT: begin
            if (i < 2)
               fmt_code[8*i +: 8] = fmt_code[8*i +: 8] | b;
            else if (i < 4)
               fmt_chans[8*(i-2) +: 8] = fmt_chans[8*(i-2) +: 8] | b;
            else if (i < 8)
               fmt_rate[8*(i-4) +: 8] = fmt_rate[8*(i-4) +: 8] | b;
            else if (i >= 14)
               fmt_bits[8*(i-14) +: 8] = fmt_bits[8*(i-14) +: 8] | b;
            byte_cnt = i + 4'd1;
            need = (chunk_len < 16) ? chunk_len : 32'd16;
            if ({28'd0, i} + 32'd1 >= need) begin
               if (fmt_code != wsf_pkg::PCM_CODE) begin
                  raise_error(wsf_pkg::ERR_UNSUPPORTED);
               end else begin
                  fmt_seen = 1'b1;
                  start_skip({1'b0, chunk_len - need} + chunk_len[0]);
               end
            end
         end
         PH_SKIP: begin
            if (skip_left > 0)
               skip_left--;
            if (skip_left == 0)
               start_skip('0);
         end
         PH_DATA: begin
            bpf = (fmt_chans == wsf_pkg::MAX_CH) ? 3'd4 : 3'd2;
            k   = {1'b0, frame_idx};
            frame_word[8*k +: 8] = frame_word[8*k +: 8] | b;
            k = k + 3'd1;
            frame_idx = k[1:0];
            if (k >= bpf) begin
               left = frame_word[15:0];
               push_result(wsf_pkg::KIND_FRAME, left,
                           (bpf == 4) ? frame_word[31:16] : left,
                           '0, '0, wsf_pkg::ERR_NONE);
               frame_word = '0;
               frame_idx  = '0;
               data_left  = (data_left > bpf) ? data_left - bpf : '0;
               if (data_left == 0) begin
                  phase = PH_DONE;
                  push_result(wsf_pkg::KIND_END, '0, '0, '0, '0, wsf_pkg::ERR_NONE);
               end
            end
         end
         default: ;
      endcase
      // End of file outside the data chunk is either a truncation or a
      // structural fault, depending on where it falls.
      if (eof && phase != PH_DONE) begin
         if (phase == PH_DATA) begin
            phase = PH_DONE;
            push_result(wsf_pkg::KIND_END, '0, '0, '0, '0, wsf_pkg::ERR_NONE);
         end else if (phase == PH_PREAMBLE || phase == PH_FORMAT ||
                      (phase == PH_CHUNK_HDR && byte_cnt != 0)) begin
            raise_error(wsf_pkg::ERR_TRUNCATED);
         end else begin
            raise_error(wsf_pkg::ERR_STRUCTURE);
         end
      end
   endtask

   // Compares one response item with the oldest expected result.
   task automatic check_result();
      wsf_pkg::result_type exp_r;
      if (expected_results.size() == 0) begin
         report($sformatf("unexpected response kind %0d", rsp_tuser));
      end else begin
         exp_r = expected_results.pop_front();
         if (rsp_tuser != exp_r.kind)
            report($sformatf("kind %0d, expected %0d", rsp_tuser, exp_r.kind));
         if (rsp_tdata[15:0] != exp_r.left_sample)
            report($sformatf("left %h, expected %h", rsp_tdata[15:0],
                             exp_r.left_sample));
         if (rsp_tdata[31:16] != exp_r.right_sample)
            report($sformatf("right %h, expected %h", rsp_tdata[31:16],
                             exp_r.right_sample));
         if (rsp_tdata[33:32] != exp_r.channel_count)
            report($sformatf("channels %0d, expected %0d", rsp_tdata[33:32],
                             exp_r.channel_count));
         if (rsp_tdata[65:34] != exp_r.rate_hz)
            report($sformatf("rate %h, expected %h", rsp_tdata[65:34],
                             exp_r.rate_hz));
         if (rsp_tdata[67:66] != exp_r.error_code)
            report($sformatf("error code %0d, expected %0d", rsp_tdata[67:66],
                             exp_r.error_code));
         if (rsp_tdata[wsf_pkg::RspDataWidth-1:68] != '0)
            report("nonzero fill bits in response data");
         case (exp_r.kind)
            wsf_pkg::KIND_FRAME:  frames_checked++;
            wsf_pkg::KIND_HEADER: headers_checked++;
            wsf_pkg::KIND_ERROR:  errors_checked++;
            default: ;
         endcase
      end
   endtask

   initial begin
      fail_count      = 0;
      frames_checked  = 0;
      headers_checked = 0;
      errors_checked  = 0;
   end

   // Requests are predicted before responses are checked; a result never
   // leaves in the cycle of its own request.
   always @(posedge clock) begin
      if (reset) begin
         duration_secs = '0;
         clear_parse();
         expected_results.delete();
      end else begin
         if (csr_wen)
            duration_secs = csr_wdata;
         if (req_tvalid && req_tready)
            predict_byte(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_result();
      end
   end

endmodule

FILE: tb/tb_wav_stream_to_stereo_frames.sv
// ---------------------------------------------------------------------------
// WAV stream to stereo frames testbench
// Feeds short WAV files, broken ones among them, byte by byte with random
// gaps and response stalls, changes the duration limit between files and
// leaves all checking to the frame checker.
// ---------------------------------------------------------------------------
module tb_wav_stream_to_stereo_frames;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ByteTarget  = 650;
   localparam int QuietFrom   = 560;
   localparam int CycleLimit  = 400000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wen;
   logic [15:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [wsf_pkg::RspDataWidth-1:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int fail_count;
   int pending_count;
   int frames_checked;
   int headers_checked;
   int errors_checked;

   int  bytes_sent;
   int  cycle_count;
   int  ready_hold;
   int  files_sent;
   int  limit_step;
   bit  quiet;
   logic [7:0] file_bytes[$];

   wav_stream_to_stereo_frames dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   wav_frame_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .frames_checked  (frames_checked),
      .headers_checked (headers_checked),
      .errors_checked  (errors_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("wav_stream_to_stereo_frames verification failed");
         $finish;
      end
   end

   // Response side stalls in random bursts until the quiet tail.
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else if (!quiet && rsp_tready && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         ready_hold = $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
         ready_hold = $urandom_range(0, 12);
      end
   end

   // Sends one request byte, after an optional idle burst.
   task automatic send_byte(input logic [7:0] b, input logic first, input logic eof);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      req_tlast  <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      quiet = (bytes_sent >= QuietFrom);
   endtask

   // Waits until every expected result is out, then writes the limit.
   task automatic write_limit(input logic [15:0] secs);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= secs;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int j = 0; j < 4; j++)
         file_bytes.push_back(w[8*j +: 8]);
   endtask

   // Appends a format chunk, usually valid PCM, sometimes odd in length or
   // content.
   task automatic add_format();
      int          flen;
      int          sel;
      logic [15:0] code;
      logic [15:0] chans;
      logic [31:0] rate;
      logic [15:0] bits;
      logic [7:0]  body[16];
      sel  = $urandom_range(0, 7);
      flen = (sel == 0) ? $urandom_range(0, 15) : (sel == 1) ? $urandom_range(17, 21) : 16;
      code  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : wsf_pkg::PCM_CODE;
      chans = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3)) :
              ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
      sel  = $urandom_range(0, 19);
      rate = (sel == 0) ? 32'd0 : (sel < 5) ? $urandom : 32'($urandom_range(1, 5));
      bits = ($urandom_range(0, 9) == 0) ? 16'($urandom) : wsf_pkg::PCM_BITS;
      for (int j = 0; j < 16; j++)
         body[j] = 8'($urandom);
      {body[1], body[0]} = code;
      {body[3], body[2]} = chans;
      {body[7], body[6], body[5], body[4]} = rate;
      {body[15], body[14]} = bits;
      add_word(wsf_pkg::TAG_FMT);
      add_word(flen);
      for (int j = 0; j < flen; j++)
         file_bytes.push_back((j < 16) ? body[j] : 8'($urandom));
      if (flen % 2 == 1)
         file_bytes.push_back(8'($urandom));
   endtask

   // Builds one file, mostly well formed, and sends it, possibly cut short.
   task automatic send_file();
      int          n_junk;
      int          data_len;
      int          n_data;
      int          cut;
      bit          with_eof;
      logic [31:0] len_word;
      file_bytes.delete();
      add_word(wsf_pkg::TAG_RIFF);
      add_word($urandom);
      add_word(wsf_pkg::TAG_WAVE);
      if ($urandom_range(0, 14) == 0)
         file_bytes[$urandom_range(0, 11)] ^= 8'h01 << $urandom_range(0, 7);
      // An unknown chunk, with a pad byte when its length is odd.
      if ($urandom_range(0, 2) == 0) begin
         add_word($urandom);
         n_junk = $urandom_range(0, 5);
         add_word(n_junk);
         repeat (n_junk + n_junk % 2) file_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(0, 19) != 0) begin
         add_format();
         if ($urandom_range(0, 9) == 0)
            add_format();
      end
      add_word(wsf_pkg::TAG_DATA);
      if ($urandom_range(0, 9) == 0) begin
         len_word = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
         n_data   = $urandom_range(4, 24);
      end else begin
         data_len = $urandom_range(0, 24);
         len_word = data_len;
         n_data   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, data_len + 3) : data_len;
      end
      add_word(len_word);
      repeat (n_data) file_bytes.push_back(8'($urandom));
      cut = file_bytes.size();
      if ($urandom_range(0, 9) == 0)
         cut = $urandom_range(1, file_bytes.size());
      with_eof = ($urandom_range(0, 5) != 0);
      for (int j = 0; j < cut; j++)
         send_byte(file_bytes[j], j == 0, with_eof && j == cut - 1);
      // Stray bytes, ignored until the next file if the parse has ended.
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
      files_sent++;
   endtask

   initial begin
      reset      = 1'b1;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      ready_hold = 0;
      bytes_sent = 0;
      cycle_count = 0;
      files_sent = 0;
      limit_step = 0;
      quiet      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_limit(16'd0);

      // Directed: a damaged preamble straight after reset, with no start
      // marker, then ignored bytes and a file cut off inside the preamble.
      file_bytes.delete();
      add_word(32'h5849_4952);
      add_word(32'h0000_0000);
      add_word(wsf_pkg::TAG_WAVE);
      foreach (file_bytes[j])
         send_byte(file_bytes[j], 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte("R", 1'b1, 1'b0);
      send_byte("I", 1'b0, 1'b0);
      send_byte("F", 1'b0, 1'b1);

      // Random files; the limit changes every few files and visits both
      // extremes.
      while (bytes_sent < ByteTarget) begin
         if (files_sent % 3 == 2) begin
            case (limit_step % 5)
               0: write_limit(16'd1);
               1: write_limit(16'hFFFF);
               2: write_limit(16'd2);
               3: write_limit(16'($urandom));
               default: write_limit(16'd0);
            endcase
            limit_step++;
         end
         send_file();
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d files and %0d request bytes sent, %0d limit changes", files_sent,
               bytes_sent, limit_step + 1);
      $display("checked %0d headers, %0d frames and %0d errors", headers_checked,
               frames_checked, errors_checked);
      if (fail_count == 0)
         $display("wav_stream_to_stereo_frames verification clean");
      else
         $display("wav_stream_to_stereo_frames verification failed");
      $finish;
   end

endmodule
